[design/vpe_pkg.sv]
// Shared types and constants for the velocity profile point evaluator.
// No dependencies; vpe_ctrl, vpe_dp and the top level refer to it by scoped names.
`default_nettype none
package vpe_pkg;

	localparam int unsigned MAX_POINTS = 32;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_COUNT = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// divider: numerator is |dv| in Q16 plus half of dt, divisor is dt
	localparam int unsigned DIV_NW = 50;
	localparam int unsigned DIV_DW = 32;

	localparam logic [3:0] DP_NOP = 4'd0;
	localparam logic [3:0] DP_WR  = 4'd1;
	localparam logic [3:0] DP_LD  = 4'd2;
	localparam logic [3:0] DP_RD  = 4'd3;
	localparam logic [3:0] DP_CHK = 4'd4;
	localparam logic [3:0] DP_ACC = 4'd5;
	localparam logic [3:0] DP_DGO = 4'd6;
	localparam logic [3:0] DP_M1  = 4'd7;
	localparam logic [3:0] DP_M2  = 4'd8;
	localparam logic [3:0] DP_M3  = 4'd9;
	localparam logic [3:0] DP_M4  = 4'd10;
	localparam logic [3:0] DP_M5  = 4'd11;
	localparam logic [3:0] DP_FIN = 4'd12;

	typedef struct packed {
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic cnt_bad;
		logic last;
		logic div_done;
	} sts_t;

endpackage
`default_nettype wire

[design/vpe_if.sv]
// Valid/ready channel interfaces for the evaluator's item and result transactions.
// Standalone; no package dependency.
`default_nettype none
interface vpe_item_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [5:0]         point_index;
	logic signed [31:0] point_time;
	logic signed [31:0] point_velocity;
	logic signed [47:0] start_position;
	logic [7:0]         point_count;
	logic signed [31:0] request_time;

	modport source (output valid, operation, point_index, point_time, point_velocity,
		start_position, point_count, request_time, input ready);
	modport sink (input valid, operation, point_index, point_time, point_velocity,
		start_position, point_count, request_time, output ready);
endinterface

interface vpe_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [4:0]         segment;
	logic signed [47:0] position;
	logic signed [31:0] velocity;
	logic signed [31:0] acceleration;

	modport source (output valid, status, segment, position, velocity, acceleration,
		input ready);
	modport sink (input valid, status, segment, position, velocity, acceleration,
		output ready);
endinterface
`default_nettype wire

[design/velocity_profile_point_evaluator_unit.sv]
// Velocity profile point evaluator, top level. Loads are written as accepted; evaluations run one at a time.
// An evaluate transaction checks the count, then walks the points (table read, check with the shared
// multiply, accumulate, per point), launches the divider for its bit-serial run and does the final
// multiplies before the result register loads; a bad count goes straight to the result register.
// The next transaction is accepted in the cycle after the result loads; a held result stalls it.
// Reset clears control only; table undefined until written. Uses vpe_pkg/vpe_if/vpe_ctrl/vpe_dp.
`default_nettype none
module velocity_profile_point_evaluator_unit #(
	parameter int unsigned MAX_POINTS = vpe_pkg::MAX_POINTS
) (
	input wire logic      clk,
	input wire logic      arst_n,
	vpe_item_if.sink      item,
	vpe_result_if.source  result
);
	vpe_pkg::cmd_t cmd;
	vpe_pkg::sts_t sts;

	vpe_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item.valid),
		.item_operation (item.operation),
		.item_ready     (item.ready),
		.result_valid   (result.valid),
		.result_ready   (result.ready),
		.cmd            (cmd),
		.sts            (sts)
	);

	vpe_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.point_index    (item.point_index),
		.point_time     (item.point_time),
		.point_velocity (item.point_velocity),
		.start_position (item.start_position),
		.point_count    (item.point_count),
		.request_time   (item.request_time),
		.status         (result.status),
		.segment        (result.segment),
		.position       (result.position),
		.velocity       (result.velocity),
		.acceleration   (result.acceleration)
	);

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.operation == vpe_pkg::OP_EVAL |=> !item.ready)
		else $error("item accepted right after an evaluate transaction");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> !item.ready)
		else $error("divider finished while idle");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != vpe_pkg::ST_OK |->
		result.segment == 5'd0 && result.position == 48'sd0 &&
		result.velocity == 32'sd0 && result.acceleration == 32'sd0)
		else $error("failed evaluation carries nonzero fields");

endmodule
`default_nettype wire

[design/vpe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module vpe_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[design/vpe_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module vpe_div #(
	parameter int unsigned NW = 50,
	parameter int unsigned DW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int unsigned CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   num_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [DW:0]     trial;
	logic [DW:0]     diff;
	logic            ge;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;
endmodule
`default_nettype wire

[design/vpe_ctrl.sv]
// Controller state machine: sequences loads, the point walk, the division and the
// final multiplies. Depends on vpe_pkg.
`default_nettype none
module vpe_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	input  wire logic           item_operation,
	output logic                item_ready,
	output logic                result_valid,
	input  wire logic           result_ready,
	output vpe_pkg::cmd_t       cmd,
	input  wire vpe_pkg::sts_t  sts
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CKN  = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_ACC  = 4'd4;
	localparam logic [3:0] S_DGO  = 4'd5;
	localparam logic [3:0] S_DW   = 4'd6;
	localparam logic [3:0] S_M1   = 4'd7;
	localparam logic [3:0] S_M2   = 4'd8;
	localparam logic [3:0] S_M3   = 4'd9;
	localparam logic [3:0] S_M4   = 4'd10;
	localparam logic [3:0] S_M5   = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_n;
	logic       rvalid_q;

	always_comb begin
		state_n    = state_q;
		cmd.op     = vpe_pkg::DP_NOP;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_operation == vpe_pkg::OP_EVAL) begin
						cmd.op  = vpe_pkg::DP_LD;
						state_n = S_CKN;
					end else begin
						cmd.op = vpe_pkg::DP_WR;
					end
				end
			end
			S_CKN: state_n = sts.cnt_bad ? S_FIN : S_RD;
			S_RD: begin
				cmd.op  = vpe_pkg::DP_RD;
				state_n = S_CHK;
			end
			S_CHK: begin
				cmd.op  = vpe_pkg::DP_CHK;
				state_n = S_ACC;
			end
			S_ACC: begin
				cmd.op  = vpe_pkg::DP_ACC;
				state_n = sts.last ? S_DGO : S_RD;
			end
			S_DGO: begin
				cmd.op  = vpe_pkg::DP_DGO;
				state_n = S_DW;
			end
			S_DW: begin
				if (sts.div_done) begin
					state_n = S_M1;
				end
			end
			S_M1: begin
				cmd.op  = vpe_pkg::DP_M1;
				state_n = S_M2;
			end
			S_M2: begin
				cmd.op  = vpe_pkg::DP_M2;
				state_n = S_M3;
			end
			S_M3: begin
				cmd.op  = vpe_pkg::DP_M3;
				state_n = S_M4;
			end
			S_M4: begin
				cmd.op  = vpe_pkg::DP_M4;
				state_n = S_M5;
			end
			S_M5: begin
				cmd.op  = vpe_pkg::DP_M5;
				state_n = S_FIN;
			end
			S_FIN: begin
				if (!rvalid_q || result_ready) begin
					cmd.op  = vpe_pkg::DP_FIN;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rvalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.op == vpe_pkg::DP_FIN) begin
				rvalid_q <= 1'b1;
			end else if (result_ready) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	assign result_valid = rvalid_q;
endmodule
`default_nettype wire

[design/vpe_dp.sv]
// Datapath: point table, walk checks, trapezoid integration, shared multiplier,
// divider and result registers. Depends on vpe_pkg, vpe_ram and vpe_div.
`default_nettype none
module vpe_dp #(
	parameter int unsigned MAX_POINTS = vpe_pkg::MAX_POINTS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vpe_pkg::cmd_t      cmd,
	output vpe_pkg::sts_t           sts,
	input  wire logic [5:0]         point_index,
	input  wire logic signed [31:0] point_time,
	input  wire logic signed [31:0] point_velocity,
	input  wire logic signed [47:0] start_position,
	input  wire logic [7:0]         point_count,
	input  wire logic signed [31:0] request_time,
	output logic [1:0]              status,
	output logic [4:0]              segment,
	output logic signed [47:0]      position,
	output logic signed [31:0]      velocity,
	output logic signed [31:0]      acceleration
);
	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);
	localparam int unsigned NW = vpe_pkg::DIV_NW;
	localparam int unsigned DW = vpe_pkg::DIV_DW;

	localparam logic signed [65:0] P48_MAX = 66'sd140737488355327;
	localparam logic signed [65:0] P48_MIN = -66'sd140737488355328;
	localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
	localparam logic signed [49:0] S32_MIN = -50'sd2147483648;
	localparam logic [62:0]        P2_CAP  = 63'h4000_0000_0000_0000;

	function automatic logic [32:0] mag33(input logic signed [32:0] x);
		return x[32] ? 33'(-x) : 33'(x);
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
		if (x > P48_MAX) begin
			return P48_MAX[47:0];
		end else if (x < P48_MIN) begin
			return P48_MIN[47:0];
		end
		return x[47:0];
	endfunction

	// table
	logic          wr_en;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [63:0]   rdata;
	logic [CW-1:0] i_q;
	logic [CW-1:0] im1;

	assign wr_en = (cmd.op == vpe_pkg::DP_WR) && (point_index != 6'd0)
		&& ({3'b000, point_index} <= 9'(MAX_POINTS));
	assign waddr = AW'(point_index - 6'd1);
	assign im1   = i_q - CW'(1);
	assign raddr = im1[AW-1:0];

	vpe_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata ({point_time, point_velocity}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// walk state
	logic signed [47:0] pos_q;
	logic [7:0]         n_q;
	logic signed [31:0] t_q;
	logic signed [31:0] prev_t_q, prev_v_q, t1_q, tn_q;
	logic signed [31:0] ts_q, vs_q, te_q, ve_q;
	logic [CW-1:0]      seg_q;
	logic               cnt_bad_q, dec_q, found_q, last_q, add_q, area_neg_q;

	logic signed [31:0] cur_t, cur_v;
	logic signed [32:0] vsum, dtw;
	logic               first, last_c, hit;

	assign cur_t  = $signed(rdata[63:32]);
	assign cur_v  = $signed(rdata[31:0]);
	assign vsum   = 33'(cur_v) + 33'(prev_v_q);
	assign dtw    = 33'(cur_t) - 33'(prev_t_q);
	assign first  = (i_q == CW'(1));
	assign last_c = (8'(i_q) == n_q);
	assign hit    = !first && !found_q && (t_q < cur_t);

	// evaluation
	logic signed [32:0] dt, dv, tau;
	logic [32:0]        dv_mag;
	logic [NW-1:0]      div_num;
	logic [NW-1:0]      quo;
	logic               div_done;
	logic               dt_pos_q, dv_neg_q;
	logic [32:0]        tau_q;
	logic signed [31:0] acc_q;
	logic [32:0]        acc_mag, vs_mag;
	logic [47:0]        vt_q, p1_q;
	logic [62:0]        atau_q;
	logic [63:0]        e_q;
	logic [62:0]        p2_q;
	logic [95:0]        p2_sum;
	logic [62:0]        p2_raw;
	logic [65:0]        mul_a_q;
	logic [32:0]        mul_a, mul_b;
	logic [65:0]        mul_q;
	logic [65:0]        rnd16, rnd17;
	logic [49:0]        area_m;
	logic signed [49:0] area_s;

	assign dt      = 33'(te_q) - 33'(ts_q);
	assign dv      = 33'(ve_q) - 33'(vs_q);
	assign tau     = 33'(t_q) - 33'(ts_q);
	assign dv_mag  = mag33(dv);
	assign div_num = 50'({dv_mag, 16'h0000}) + 50'(dt[31:1]);
	assign acc_mag = mag33(33'(acc_q));
	assign vs_mag  = mag33(33'(vs_q));

	vpe_div #(.NW(NW), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == vpe_pkg::DP_DGO),
		.num    (div_num),
		.den    (dt[DW-1:0]),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			vpe_pkg::DP_CHK: begin
				mul_a = mag33(vsum);
				mul_b = mag33(dtw);
			end
			vpe_pkg::DP_M1: begin
				mul_a = acc_mag;
				mul_b = tau_q;
			end
			vpe_pkg::DP_M2: begin
				mul_a = vs_mag;
				mul_b = tau_q;
			end
			vpe_pkg::DP_M3: begin
				mul_a = {1'b0, atau_q[31:0]};
				mul_b = tau_q;
			end
			vpe_pkg::DP_M4: begin
				mul_a = {2'b00, atau_q[62:32]};
				mul_b = tau_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_a_q = 66'(mul_a);
	assign rnd16   = mul_q + 66'h1_0000 / 66'd2;
	assign rnd17   = mul_q + 66'h1_0000;
	assign area_m  = 50'(rnd17[65:17]);
	assign area_s  = area_neg_q ? -$signed(area_m) : $signed(area_m);
	assign p2_sum  = {32'h0, e_q} + {mul_q[63:0], 32'h0} + 96'h1_0000_0000;
	assign p2_raw  = p2_sum[95:33];

	// result assembly
	logic [1:0]         stat;
	logic signed [49:0] vt_s, v_sum;
	logic signed [65:0] p1_s, p2_s, x_sum;
	logic signed [31:0] v_sat;

	assign stat = cnt_bad_q ? vpe_pkg::ST_COUNT
		: dec_q ? vpe_pkg::ST_ORDER
		: ((t_q < t1_q) || (t_q > tn_q)) ? vpe_pkg::ST_RANGE
		: vpe_pkg::ST_OK;
	assign vt_s  = acc_q[31] ? -$signed({2'b00, vt_q}) : $signed({2'b00, vt_q});
	assign v_sum = 50'(vs_q) + vt_s;
	assign v_sat = (v_sum > S32_MAX) ? S32_MAX[31:0]
		: (v_sum < S32_MIN) ? S32_MIN[31:0] : v_sum[31:0];
	assign p1_s  = vs_q[31] ? -$signed({18'h0, p1_q}) : $signed({18'h0, p1_q});
	assign p2_s  = acc_q[31] ? -$signed({3'b000, p2_q}) : $signed({3'b000, p2_q});
	assign x_sum = 66'(pos_q) + p1_s + p2_s;

	always_ff @(posedge clk) begin
		mul_q <= mul_a_q * 66'(mul_b);
		case (cmd.op)
			vpe_pkg::DP_LD: begin
				pos_q     <= start_position;
				n_q       <= point_count;
				t_q       <= request_time;
				i_q       <= CW'(1);
				cnt_bad_q <= (point_count < 8'd2) || ({1'b0, point_count} > 9'(MAX_POINTS));
				dec_q     <= 1'b0;
				found_q   <= 1'b0;
				add_q     <= 1'b0;
				last_q    <= 1'b0;
			end
			vpe_pkg::DP_CHK: begin
				if (first) begin
					t1_q <= cur_t;
				end else if (cur_t < prev_t_q) begin
					dec_q <= 1'b1;
				end
				if (last_c) begin
					tn_q <= cur_t;
				end
				if (!first && !found_q && (hit || last_c)) begin
					ts_q  <= prev_t_q;
					vs_q  <= prev_v_q;
					te_q  <= cur_t;
					ve_q  <= cur_v;
					seg_q <= im1;
				end
				if (hit) begin
					found_q <= 1'b1;
				end
				add_q      <= !first && !found_q && !hit && !last_c;
				area_neg_q <= vsum[32] ^ dtw[32];
				last_q     <= last_c;
				prev_t_q   <= cur_t;
				prev_v_q   <= cur_v;
			end
			vpe_pkg::DP_ACC: begin
				if (add_q) begin
					pos_q <= sat48(66'(50'(pos_q) + area_s));
				end
				i_q <= i_q + CW'(1);
			end
			vpe_pkg::DP_DGO: begin
				dt_pos_q <= !dt[32] && (dt != 33'sd0);
				dv_neg_q <= dv[32];
				tau_q    <= tau;
			end
			vpe_pkg::DP_M2: begin
				vt_q   <= rnd16[63:16];
				atau_q <= mul_q[62:0];
			end
			vpe_pkg::DP_M3: p1_q <= rnd16[63:16];
			vpe_pkg::DP_M4: e_q <= mul_q[63:0];
			vpe_pkg::DP_M5: p2_q <= (p2_raw > P2_CAP) ? P2_CAP : p2_raw;
			vpe_pkg::DP_FIN: begin
				status <= stat;
				if (stat == vpe_pkg::ST_OK) begin
					segment      <= 5'(seg_q);
					position     <= sat48(x_sum);
					velocity     <= v_sat;
					acceleration <= acc_q;
				end else begin
					segment      <= '0;
					position     <= '0;
					velocity     <= '0;
					acceleration <= '0;
				end
			end
			default: ;
		endcase
		if (div_done) begin
			if (!dt_pos_q) begin
				acc_q <= '0;
			end else if (dv_neg_q) begin
				acc_q <= (quo > NW'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(quo[31:0]);
			end else begin
				acc_q <= (quo > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
			end
		end
	end

	assign sts.cnt_bad  = cnt_bad_q;
	assign sts.last     = last_q;
	assign sts.div_done = div_done;
endmodule
`default_nettype wire

[sim/velocity_profile_point_evaluator_unit_tb.sv]
// Self-checking testbench for velocity_profile_point_evaluator_unit: point loads and profile
// evaluations with random idling on both sides, checked against an in-bench profile evaluator.
// Depends on vpe_pkg, vpe_if and the RTL top level.
`timescale 1ns / 100ps
module velocity_profile_point_evaluator_unit_tb;

	localparam int  LIMIT_CYCLES = 1000000;
	localparam int  HOLD_CYCLES  = 400;
	localparam int  HOLD_AT      = 100;
	localparam longint P48_MAX = 64'sd140737488355327;
	localparam longint P48_MIN = -64'sd140737488355328;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct {
		logic               operation;
		logic [5:0]         point_index;
		logic signed [31:0] point_time;
		logic signed [31:0] point_velocity;
		logic signed [47:0] start_position;
		logic [7:0]         point_count;
		logic signed [31:0] request_time;
	} profile_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         segment;
		logic signed [47:0] position;
		logic signed [31:0] velocity;
		logic signed [31:0] acceleration;
	} eval_result_t;

	logic clk;
	logic arst_n;

	vpe_item_if   item_ch ();
	vpe_result_if result_ch ();

	velocity_profile_point_evaluator_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	profile_item_t pending_items[$];
	eval_result_t  expected_results[$];
	longint        time_tab[1:vpe_pkg::MAX_POINTS];
	longint        vel_tab[1:vpe_pkg::MAX_POINTS];

	// stimulus-side view of the table, used to keep every read on a written entry
	longint        gen_time[1:vpe_pkg::MAX_POINTS];
	bit            gen_written[1:vpe_pkg::MAX_POINTS];

	int  errors;
	int  cycle_cnt;
	int  accepted_evals;
	int  load_cnt;
	int  eval_cnt;
	int  status_cnt[4];
	bit  quiet;
	int  send_gap;
	int  recv_gap;
	int  hold_left;
	bit  hold_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// rounded a*b >> sh, ties away from zero, magnitude capped at 2^62
	function automatic longint mul_round(longint a, longint b, int sh);
		logic [63:0]  ma;
		logic [63:0]  mb;
		logic [127:0] p;
		bit           neg;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? 64'(-a) : 64'(a);
		mb = b < 0 ? 64'(-b) : 64'(b);
		p = {64'd0, ma} * {64'd0, mb};
		p = (p + (128'd1 << (sh - 1))) >> sh;
		if (p > (128'd1 << 62)) begin
			p = 128'd1 << 62;
		end
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic eval_result_t evaluate_profile(profile_item_t it);
		eval_result_t r;
		int           n;
		int           seg;
		bit           found;
		longint       t, pos, dt, dv, acc, tau, v, x;
		longint unsigned m, q;
		r = '0;
		n = int'(it.point_count);
		t = longint'(it.request_time);
		if (n < 2 || n > vpe_pkg::MAX_POINTS) begin
			r.status = vpe_pkg::ST_COUNT;
			return r;
		end
		for (int i = 2; i <= n; i++) begin
			if (time_tab[i] < time_tab[i-1]) begin
				r.status = vpe_pkg::ST_ORDER;
				return r;
			end
		end
		if (t < time_tab[1] || t > time_tab[n]) begin
			r.status = vpe_pkg::ST_RANGE;
			return r;
		end
		seg = n - 1;
		found = 1'b0;
		if (t != time_tab[n]) begin
			for (int i = 2; i <= n; i++) begin
				if (!found && t < time_tab[i]) begin
					seg = i - 1;
					found = 1'b1;
				end
			end
		end
		pos = longint'(it.start_position);
		for (int i = 2; i <= seg; i++) begin
			pos = clamp(pos + mul_round(vel_tab[i] + vel_tab[i-1],
				time_tab[i] - time_tab[i-1], 17), P48_MIN, P48_MAX);
		end
		dt = time_tab[seg+1] - time_tab[seg];
		acc = 0;
		if (dt > 0) begin
			dv = vel_tab[seg+1] - vel_tab[seg];
			m = (dv < 0 ? 64'(-dv) : 64'(dv)) << 16;
			q = (m + 64'(dt) / 2) / 64'(dt);
			if (dv < 0) begin
				acc = q > 64'd2147483648 ? S32_MIN : -longint'(q);
			end else begin
				acc = q > 64'd2147483647 ? S32_MAX : longint'(q);
			end
		end
		tau = t - time_tab[seg];
		v = clamp(vel_tab[seg] + mul_round(acc, tau, 16), S32_MIN, S32_MAX);
		x = pos + mul_round(vel_tab[seg], tau, 16) + mul_round(acc * tau, tau, 33);
		x = clamp(x, P48_MIN, P48_MAX);
		r.status = vpe_pkg::ST_OK;
		r.segment = 5'(seg);
		r.position = 48'(x);
		r.velocity = 32'(v);
		r.acceleration = 32'(acc);
		return r;
	endfunction

	function automatic profile_item_t random_item();
		profile_item_t it;
		it.operation = 1'($urandom_range(0, 1));
		it.point_index = 6'($urandom);
		it.point_time = 32'($urandom);
		it.point_velocity = 32'($urandom);
		it.start_position = 48'({$urandom, $urandom});
		it.point_count = 8'($urandom);
		it.request_time = 32'($urandom);
		return it;
	endfunction

	task automatic push_load(int idx, longint pt, longint pv);
		profile_item_t it;
		it = random_item();
		it.operation = vpe_pkg::OP_LOAD;
		it.point_index = 6'(idx);
		it.point_time = 32'(pt);
		it.point_velocity = 32'(pv);
		if (idx >= 1 && idx <= vpe_pkg::MAX_POINTS) begin
			gen_written[idx] = 1'b1;
			gen_time[idx] = pt;
		end
		pending_items.push_back(it);
	endtask

	// a count that would touch an unwritten entry is cut back to the written prefix, or to 0 if that is under 2
	task automatic push_eval(int cnt, longint rt, longint sp);
		profile_item_t it;
		int            ok;
		it = random_item();
		it.operation = vpe_pkg::OP_EVAL;
		if (cnt >= 2 && cnt <= vpe_pkg::MAX_POINTS) begin
			ok = 0;
			while (ok < cnt && gen_written[ok+1]) ok++;
			cnt = ok < 2 ? 0 : ok;
		end
		it.point_count = 8'(cnt);
		it.request_time = 32'(rt);
		it.start_position = 48'(sp);
		pending_items.push_back(it);
	endtask

	function automatic longint rand_vel(bit full);
		return full ? longint'(int'($urandom)) : longint'($urandom_range(0, 2**21)) - 2**20;
	endfunction

	task automatic push_profile();
		int     n;
		int     mode;
		int     evals;
		longint t;
		longint sp;
		n = $urandom_range(0, 3) == 0 ? $urandom_range(2, vpe_pkg::MAX_POINTS)
			: $urandom_range(2, 8);
		mode = $urandom_range(0, 2);
		t = longint'($urandom_range(0, 2**31 - 1)) - 2**30;
		for (int i = 1; i <= n; i++) begin
			if (i > 1) begin
				case (mode)
					0: t += $urandom_range(0, 3);
					1: t += $urandom_range(0, 2**20);
					default: t += $urandom_range(0, 2**25);
				endcase
			end
			push_load(i, t, rand_vel($urandom_range(0, 1)));
		end
		evals = $urandom_range(1, 4);
		for (int k = 0; k < evals; k++) begin
			sp = $urandom_range(0, 3) == 0 ? longint'({$urandom, $urandom}) >>> 16
				: longint'($urandom_range(0, 2**20)) - 2**19;
			case ($urandom_range(0, 3))
				0: push_eval(n, gen_time[$urandom_range(1, n)], sp);
				default: push_eval(n, gen_time[1]
					+ longint'($urandom_range(0, 32'(gen_time[n] - gen_time[1]))), sp);
			endcase
		end
	endtask

	task automatic push_noise();
		profile_item_t it;
		it = random_item();
		case ($urandom_range(0, 3))
			0: push_load($urandom_range(0, 63), longint'(it.point_time),
				longint'(it.point_velocity));
			1: push_eval($urandom_range(0, 255), longint'(it.request_time),
				longint'(it.start_position));
			2: push_eval($urandom_range(2, vpe_pkg::MAX_POINTS), longint'(it.request_time),
				longint'(it.start_position));
			default: push_load($urandom_range(1, vpe_pkg::MAX_POINTS),
				longint'($urandom_range(0, 2**31 - 1)) - 2**30, rand_vel(1'b1));
		endcase
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n && (!item_ch.valid || item_ch.ready)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				item_ch.valid <= 1'b0;
			end else if (!quiet && (cycle_cnt / 500) % 3 != 0 && $urandom_range(0, 11) == 0) begin
				send_gap <= $urandom_range(0, 16);
				item_ch.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item_ch.valid <= 1'b1;
				item_ch.operation <= pending_items[0].operation;
				item_ch.point_index <= pending_items[0].point_index;
				item_ch.point_time <= pending_items[0].point_time;
				item_ch.point_velocity <= pending_items[0].point_velocity;
				item_ch.start_position <= pending_items[0].start_position;
				item_ch.point_count <= pending_items[0].point_count;
				item_ch.request_time <= pending_items[0].request_time;
				void'(pending_items.pop_front());
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
		if (pending_items.size() < 100) begin
			quiet <= 1'b1;
		end
	end

	// accepted transactions update the table model and queue the expected result
	always @(posedge clk) begin
		profile_item_t it;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			it.operation = item_ch.operation;
			it.point_index = item_ch.point_index;
			it.point_time = item_ch.point_time;
			it.point_velocity = item_ch.point_velocity;
			it.start_position = item_ch.start_position;
			it.point_count = item_ch.point_count;
			it.request_time = item_ch.request_time;
			if (it.operation == vpe_pkg::OP_LOAD) begin
				load_cnt++;
				if (it.point_index >= 1 && it.point_index <= vpe_pkg::MAX_POINTS) begin
					time_tab[it.point_index] = longint'(it.point_time);
					vel_tab[it.point_index] = longint'(it.point_velocity);
				end
			end else begin
				eval_cnt++;
				expected_results.push_back(evaluate_profile(it));
			end
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	always @(posedge clk) begin
		if (!hold_done && accepted_evals >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver
	always @(posedge clk) begin
		if (recv_gap > 0) begin
			recv_gap = recv_gap - 1;
		end else if (!quiet && (cycle_cnt / 700) % 3 != 1 && $urandom_range(0, 9) == 0) begin
			recv_gap = $urandom_range(1, 17);
		end
		result_ch.ready <= hold_left == 0 && recv_gap == 0;
	end

	// result checker
	always @(posedge clk) begin
		eval_result_t got;
		eval_result_t exp_r;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.status = result_ch.status;
			got.segment = result_ch.segment;
			got.position = result_ch.position;
			got.velocity = result_ch.velocity;
			got.acceleration = result_ch.acceleration;
			accepted_evals <= accepted_evals + 1;
			status_cnt[got.status]++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transaction st=%0d seg=%0d pos=%0d vel=%0d acc=%0d",
					$time, got.status, got.segment, got.position, got.velocity,
					got.acceleration);
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r) begin
					errors++;
					$display("%0t: mismatch exp st=%0d seg=%0d pos=%0d vel=%0d acc=%0d",
						$time, exp_r.status, exp_r.segment, exp_r.position,
						exp_r.velocity, exp_r.acceleration);
					$display("%0t:          got st=%0d seg=%0d pos=%0d vel=%0d acc=%0d",
						$time, got.status, got.segment, got.position, got.velocity,
						got.acceleration);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("timeout: %0d results still pending", expected_results.size());
			$display("velocity_profile_point_evaluator_unit_tb: FAIL");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycle_cnt = 0;
		accepted_evals = 0;
		load_cnt = 0;
		eval_cnt = 0;
		status_cnt = '{0, 0, 0, 0};
		quiet = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		hold_left = 0;
		hold_done = 1'b0;
		for (int i = 1; i <= vpe_pkg::MAX_POINTS; i++) begin
			time_tab[i] = 0;
			vel_tab[i] = 0;
			gen_time[i] = 0;
			gen_written[i] = 1'b0;
		end
		item_ch.valid = 1'b0;
		item_ch.operation = vpe_pkg::OP_LOAD;
		item_ch.point_index = '0;
		item_ch.point_time = '0;
		item_ch.point_velocity = '0;
		item_ch.start_position = '0;
		item_ch.point_count = '0;
		item_ch.request_time = '0;
		result_ch.ready = 1'b0;
		arst_n = 1'b0;

		// ignored load indexes, bad counts, extreme times and velocities
		push_load(0, S32_MAX, S32_MIN);
		push_load(63, S32_MIN, S32_MAX);
		push_load(33, 0, 0);
		push_eval(0, 0, 0);
		push_eval(255, 0, 0);
		push_eval(33, 0, 0);
		push_load(1, S32_MIN, S32_MAX);
		push_load(2, S32_MIN, S32_MIN);
		push_load(3, S32_MAX, S32_MAX);
		push_eval(2, S32_MIN, P48_MIN);      // zero-length segment, time on last point
		push_eval(3, S32_MAX, P48_MAX);      // last point uses last segment
		push_eval(3, 0, 0);
		push_eval(1, 0, 0);
		push_load(1, 0, S32_MIN);            // acceleration saturates high
		push_load(2, 1, S32_MAX);
		push_load(3, 100, S32_MAX);
		push_eval(3, 1, 0);
		push_eval(3, 101, 0);                // past last point
		push_eval(3, -1, 0);                 // before first point
		push_load(2, 200, S32_MAX);          // times decreasing
		push_eval(3, 50, 0);
		push_load(32, 7, 7);
		push_eval(vpe_pkg::MAX_POINTS, 7, 0);

		while (pending_items.size() < 900) begin
			if ($urandom_range(0, 4) == 0) begin
				push_noise();
			end else begin
				push_profile();
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || item_ch.valid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("ran %0d loads and %0d evaluations", load_cnt, eval_cnt);
		$display("status ok/count/order/range: %0d/%0d/%0d/%0d",
			status_cnt[0], status_cnt[1], status_cnt[2], status_cnt[3]);
		if (errors == 0) begin
			$display("velocity_profile_point_evaluator_unit_tb: PASS");
		end else begin
			$display("velocity_profile_point_evaluator_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

[velocity_profile_point_evaluator_unit.f]
design/vpe_pkg.sv
design/vpe_if.sv
design/vpe_ram.sv
design/vpe_div.sv
design/vpe_ctrl.sv
design/vpe_dp.sv
design/velocity_profile_point_evaluator_unit.sv
sim/velocity_profile_point_evaluator_unit_tb.sv
